>>> hdl/ppgbit_pkg.sv
// Package for the PPG beat interval tracker.
// Field widths, register codes, fixed constants and the history control struct.
// No dependencies.
package ppgbit_pkg;

    localparam int CFG_LEVEL_W = 18;
    localparam int MS_W        = 7;
    localparam int BPM_W       = 9;
    localparam int CFG_DATA_W  = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int INTERVAL_W  = 12;
    localparam int RATE_W      = 10;
    localparam int CONF_W      = 7;
    localparam int VCOUNT_W    = 4;

    localparam int DEF_HISTORY_DEPTH = 10;
    localparam int DEF_SAMPLE_BITS   = 18;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MS_PER_SAMPLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BPM         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BPM         = 2'd3;

    localparam logic [CFG_LEVEL_W-1:0] RST_MIN_VALID_LEVEL = 18'd50000;
    localparam logic [MS_W-1:0]        RST_MS_PER_SAMPLE   = 7'd5;
    localparam logic [BPM_W-1:0]       RST_MIN_BPM         = 9'd40;
    localparam logic [BPM_W-1:0]       RST_MAX_BPM         = 9'd200;

    localparam int BPM_NUMERATOR  = 60000;
    localparam int TIMEOUT_MS     = 2500;
    localparam int REFRACTORY_MS  = 250;
    localparam int INTERVAL_RESET = 600;
    localparam int THRESH_OFFSET  = 500;
    localparam int MAX_VALID      = 10;

    // x / 5 == (x * RECIP5) >> RECIP5_SHIFT for x below 2**14
    localparam int RECIP5       = 3277;
    localparam int RECIP5_SHIFT = 14;

    typedef struct packed {
        logic fill;
        logic shift;
    } hist_ctrl_t;

endpackage

>>> hdl/ppg_beat_interval_tracker_core.sv
// PPG beat interval tracker, top level: sample evaluation, sequencer, output register.
// Depends on ppgbit_pkg, ppgbit_history, ppgbit_serial_div.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   s_ir_sample
//  m_       out        m_valid / m_ready   finger, beat, interval, bpm, confidence, timeout
//  cfg_     in         cfg_we              cfg_index, cfg_wdata
//
// A sample without a rated beat passes ST_EVAL and ST_DONE, and its result is loaded into the
// output register on leaving ST_DONE. A beat that yields a rate runs two bit-serial divisions
// (sum / depth, then 60000 / average; the second is skipped if the average is zero).
// One sample is in work at a time; s_ready is high when idle.
// Reset is synchronous, active low; no clearing pass. A result waiting in the output
// register does not hold off the next accept, but that sample then waits in ST_DONE.
module ppg_beat_interval_tracker_core #(
    parameter int HISTORY_DEPTH = ppgbit_pkg::DEF_HISTORY_DEPTH,
    parameter int SAMPLE_BITS   = ppgbit_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [ppgbit_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppgbit_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [SAMPLE_BITS-1:0]               s_ir_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_finger_present,
    output logic                                 m_beat_detected,
    output logic [ppgbit_pkg::INTERVAL_W-1:0]    m_beat_interval_ms,
    output logic signed [ppgbit_pkg::RATE_W-1:0] m_heart_rate_bpm,
    output logic [ppgbit_pkg::CONF_W-1:0]        m_confidence_pct,
    output logic                                 m_timed_out
);
    import ppgbit_pkg::*;

    localparam int LVL_W = (SAMPLE_BITS > CFG_LEVEL_W + 1) ? SAMPLE_BITS : CFG_LEVEL_W + 1;
    localparam int SUM_W = $clog2(HISTORY_DEPTH * ((2**INTERVAL_W) - 1) + 1);
    localparam int DIV_W = (SUM_W > 16) ? SUM_W : 16;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_AVG  = 3'd3;
    localparam logic [2:0] ST_BPM  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // configuration
    logic [CFG_LEVEL_W-1:0] mvl_reg;
    logic [MS_W-1:0]        ms_reg;
    logic [BPM_W-1:0]       min_bpm_reg;
    logic [BPM_W-1:0]       max_bpm_reg;

    // tracking state
    logic [2:0]              state_reg, state_next;
    logic [SAMPLE_BITS-1:0]  s_reg;
    logic [INTERVAL_W-1:0]   elapsed_reg, elapsed_next;
    logic [LVL_W-1:0]        peak_reg, peak_next;
    logic [LVL_W-1:0]        trough_reg, trough_next;
    logic [LVL_W-1:0]        thr_reg, thr_next;
    logic [INTERVAL_W-1:0]   last_reg, last_next;
    logic                    first_reg, first_next;
    logic                    second_reg, second_next;
    logic                    above_reg, above_next;
    logic                    seeded_reg, seeded_next;
    logic [RATE_W-1:0]       rate_reg, rate_next;
    logic [VCOUNT_W-1:0]     vcount_reg, vcount_next;
    logic                    present_reg, present_next;
    logic                    beat_reg, beat_next;
    logic                    tmo_reg, tmo_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic                    o_present_reg, o_beat_reg, o_tmo_reg;
    logic [INTERVAL_W-1:0]   o_interval_reg;
    logic [RATE_W-1:0]       o_rate_reg;
    logic [CONF_W-1:0]       o_conf_reg;
    logic                    o_load;

    // evaluation terms
    logic [LVL_W-1:0]          s_ext, mvl_ext, peak_n, trough_n, mid, spread;
    logic [INTERVAL_W-1:0]     n, gate;
    logic [2*INTERVAL_W-1:0]   prod5;
    logic [INTERVAL_W-3:0]     q5;
    logic                      present, lo, hi, beat, skip, tmo;

    hist_ctrl_t              hist_ctrl;
    logic [SUM_W-1:0]        hist_sum;
    logic                    div_start, div_done;
    logic [DIV_W-1:0]        div_dividend, div_divisor, div_quotient;
    logic                    bpm_ok;

    ppgbit_history #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_history (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .hist_ctrl(hist_ctrl),
        .value    (last_next),
        .sum      (hist_sum)
    );

    ppgbit_serial_div #(
        .W(DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvl_reg     <= RST_MIN_VALID_LEVEL;
            ms_reg      <= RST_MS_PER_SAMPLE;
            min_bpm_reg <= RST_MIN_BPM;
            max_bpm_reg <= RST_MAX_BPM;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_VALID_LEVEL: mvl_reg     <= cfg_wdata[CFG_LEVEL_W-1:0];
                REG_MS_PER_SAMPLE:   ms_reg      <= cfg_wdata[MS_W-1:0];
                REG_MIN_BPM:         min_bpm_reg <= cfg_wdata[BPM_W-1:0];
                REG_MAX_BPM:         max_bpm_reg <= cfg_wdata[BPM_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        s_ext    = LVL_W'(s_reg);
        mvl_ext  = LVL_W'(mvl_reg);
        present  = (s_ext >= mvl_ext);
        n        = elapsed_reg + INTERVAL_W'(ms_reg);
        prod5    = (2*INTERVAL_W)'(last_reg) * (2*INTERVAL_W)'(RECIP5);
        q5       = prod5[RECIP5_SHIFT+INTERVAL_W-3:RECIP5_SHIFT];
        gate     = INTERVAL_W'({q5, 1'b0}) + INTERVAL_W'(q5);
        lo       = (s_ext < thr_reg);
        hi       = (s_ext > thr_reg);
        trough_n = (lo && (n > gate) && (s_ext < trough_reg)) ? s_ext : trough_reg;
        peak_n   = (hi && (s_ext > peak_reg)) ? s_ext : peak_reg;
        spread   = peak_n - trough_n;
        mid      = (spread >> 1) + trough_n;
        beat     = 1'b0;
        skip     = 1'b0;
        tmo      = 1'b0;
        bpm_ok   = (div_quotient >= DIV_W'(min_bpm_reg)) &&
                   (div_quotient <= DIV_W'(max_bpm_reg));

        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        peak_next    = peak_reg;
        trough_next  = trough_reg;
        thr_next     = thr_reg;
        last_next    = last_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        above_next   = above_reg;
        seeded_next  = seeded_reg;
        rate_next    = rate_reg;
        vcount_next  = vcount_reg;
        present_next = present_reg;
        beat_next    = beat_reg;
        tmo_next     = tmo_reg;
        hist_ctrl    = '0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(hist_sum);
        div_divisor  = DIV_W'(HISTORY_DEPTH);
        o_load       = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_DONE;
                if (!present) begin
                    elapsed_next = n;
                    tmo          = (n > INTERVAL_W'(TIMEOUT_MS));
                end else if (!seeded_reg) begin
                    peak_next    = s_ext;
                    trough_next  = s_ext;
                    thr_next     = s_ext;
                    seeded_next  = 1'b1;
                    elapsed_next = '0;
                end else begin
                    trough_next  = trough_n;
                    peak_next    = peak_n;
                    elapsed_next = n;
                    beat = (n > INTERVAL_W'(REFRACTORY_MS)) && hi && !above_reg && (n > gate);
                    if (beat) begin
                        above_next   = 1'b1;
                        last_next    = n;
                        elapsed_next = '0;
                        if (first_reg) begin
                            first_next  = 1'b0;
                            second_next = 1'b1;
                            skip        = 1'b1;
                        end else begin
                            second_next     = 1'b0;
                            hist_ctrl.fill  = second_reg;
                            hist_ctrl.shift = !second_reg;
                        end
                    end
                    if (!skip) begin
                        if (lo && above_reg) begin
                            above_next  = 1'b0;
                            thr_next    = mid;
                            peak_next   = mid;
                            trough_next = mid;
                        end
                        tmo = (n > INTERVAL_W'(TIMEOUT_MS));
                        if (beat && !tmo) begin
                            state_next = ST_SUM;
                        end
                    end
                end
                if (tmo) begin
                    thr_next     = mvl_ext + LVL_W'(THRESH_OFFSET);
                    peak_next    = mvl_ext;
                    trough_next  = mvl_ext;
                    elapsed_next = '0;
                    first_next   = 1'b1;
                    second_next  = 1'b0;
                    above_next   = 1'b0;
                    rate_next    = '1;
                    vcount_next  = '0;
                end
                present_next = present;
                beat_next    = beat;
                tmo_next     = tmo;
            end
            ST_SUM: begin
                div_start  = 1'b1;
                state_next = ST_AVG;
            end
            ST_AVG: begin
                div_dividend = DIV_W'(BPM_NUMERATOR);
                div_divisor  = div_quotient;
                if (div_done) begin
                    if (div_quotient == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_BPM;
                    end
                end
            end
            ST_BPM: begin
                if (div_done) begin
                    if (bpm_ok) begin
                        rate_next = div_quotient[RATE_W-1:0];
                        if (vcount_reg < VCOUNT_W'(MAX_VALID)) begin
                            vcount_next = vcount_reg + 1'b1;
                        end
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    o_load       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            peak_reg    <= LVL_W'(RST_MIN_VALID_LEVEL);
            trough_reg  <= LVL_W'(RST_MIN_VALID_LEVEL);
            thr_reg     <= LVL_W'(RST_MIN_VALID_LEVEL) + LVL_W'(THRESH_OFFSET);
            last_reg    <= INTERVAL_W'(INTERVAL_RESET);
            first_reg   <= 1'b1;
            second_reg  <= 1'b0;
            above_reg   <= 1'b0;
            seeded_reg  <= 1'b0;
            rate_reg    <= '1;
            vcount_reg  <= '0;
            present_reg <= 1'b0;
            beat_reg    <= 1'b0;
            tmo_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            peak_reg    <= peak_next;
            trough_reg  <= trough_next;
            thr_reg     <= thr_next;
            last_reg    <= last_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            above_reg   <= above_next;
            seeded_reg  <= seeded_next;
            rate_reg    <= rate_next;
            vcount_reg  <= vcount_next;
            present_reg <= present_next;
            beat_reg    <= beat_next;
            tmo_reg     <= tmo_next;
            m_valid_reg <= m_valid_next;
        end
        if (s_valid && s_ready) begin
            s_reg <= s_ir_sample;
        end
        if (o_load) begin
            o_present_reg  <= present_reg;
            o_beat_reg     <= beat_reg;
            o_tmo_reg      <= tmo_reg;
            o_interval_reg <= last_reg;
            o_rate_reg     <= rate_reg;
            o_conf_reg     <= CONF_W'({vcount_reg, 3'b000}) + CONF_W'({vcount_reg, 1'b0});
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_finger_present   = o_present_reg;
    assign m_beat_detected    = o_beat_reg;
    assign m_beat_interval_ms = o_interval_reg;
    assign m_heart_rate_bpm   = o_rate_reg;
    assign m_confidence_pct   = o_conf_reg;
    assign m_timed_out        = o_tmo_reg;

    a_beat_needs_finger: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_beat_detected || m_finger_present))
        else $error("beat reported without finger");

    a_timeout_clears_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_timed_out) |-> ((m_heart_rate_bpm == -10'sd1) && (m_confidence_pct == '0)))
        else $error("timeout result carries a rate");

    a_elapsed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (elapsed_reg <= INTERVAL_W'(TIMEOUT_MS)))
        else $error("elapsed time past timeout while idle");

    a_peak_over_trough: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= trough_reg)
        else $error("peak below trough");

endmodule

>>> hdl/ppgbit_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// No dependencies; standalone logic.
module ppgbit_serial_div #(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W:0]       rem_sh;
    logic [W:0]       diff;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

>>> hdl/ppgbit_history.sv
// Interval history shift line, which can also be filled with one value, with a running sum of its entries.
// Depends on ppgbit_pkg (INTERVAL_W, INTERVAL_RESET, DEF_HISTORY_DEPTH, hist_ctrl_t).
module ppgbit_history #(
    parameter int HISTORY_DEPTH = ppgbit_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ppgbit_pkg::hist_ctrl_t               hist_ctrl,
    input  logic [ppgbit_pkg::INTERVAL_W-1:0]    value,
    output logic [$clog2(HISTORY_DEPTH*((2**ppgbit_pkg::INTERVAL_W)-1)+1)-1:0] sum
);
    import ppgbit_pkg::*;

    localparam int SUM_W = $clog2(HISTORY_DEPTH * ((2**INTERVAL_W) - 1) + 1);
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(HISTORY_DEPTH * INTERVAL_RESET);

    logic [INTERVAL_W-1:0] hist_reg  [HISTORY_DEPTH];
    logic [INTERVAL_W-1:0] hist_next [HISTORY_DEPTH];
    logic [SUM_W-1:0]      sum_reg, sum_next;

    always_comb begin
        hist_next = hist_reg;
        sum_next  = sum_reg;
        if (hist_ctrl.fill) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_next[i] = value;
            end
            sum_next = SUM_W'(value) * SUM_W'(HISTORY_DEPTH);
        end else if (hist_ctrl.shift) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                hist_next[i] = hist_reg[i+1];
            end
            hist_next[HISTORY_DEPTH-1] = value;
            sum_next = sum_reg - SUM_W'(hist_reg[0]) + SUM_W'(value);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= INTERVAL_W'(INTERVAL_RESET);
            end
            sum_reg <= SUM_RESET;
        end else begin
            hist_reg <= hist_next;
            sum_reg  <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule
